// ===== design/pjd_pkg.sv =====
`default_nettype none

package pjd_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int NUM_PRIORITIES = 3;
    localparam int NUM_COUNTERS   = 16;

    localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int PRIO_W  = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int SLOT_N  = NUM_PRIORITIES * QUEUE_DEPTH;
    localparam int SLOT_AW = $clog2(SLOT_N);
    localparam int CIDX_W  = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
    localparam int PEND_W  = $clog2(SLOT_N + 1);
    localparam int PEND_MAX = 63;

    typedef enum logic [1:0] {
        KIND_SUBMIT = 2'd0,
        KIND_TAKE   = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_SET    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_NONE = 2'd2
    } t_status;

    // one stored job
    typedef struct packed {
        logic [15:0] handle;
        logic        has_ctr;
        logic [3:0]  ctr_id;
    } t_slot;

    typedef struct packed {
        logic               en;
        logic [SLOT_AW-1:0] addr;
        t_slot              data;
    } t_slot_wr;

    typedef struct packed {
        logic               en;
        logic [SLOT_AW-1:0] addr;
    } t_slot_rd;

    typedef struct packed {
        logic              en;
        logic [CIDX_W-1:0] addr;
        logic [15:0]       data;
    } t_ctr_wr;

    typedef struct packed {
        logic              en;
        logic [CIDX_W-1:0] addr;
    } t_ctr_rd;

    // counter id folded into the counter range, built at elaboration
    typedef logic [CIDX_W-1:0] t_ctr_map [16];

    function automatic t_ctr_map build_ctr_map();
        t_ctr_map m;
        for (int i = 0; i < 16; i++) begin
            m[i] = CIDX_W'(i % NUM_COUNTERS);
        end
        return m;
    endfunction

    localparam t_ctr_map CTR_MAP = build_ctr_map();

    function automatic logic [SLOT_AW-1:0] slot_addr(input logic [PRIO_W-1:0] q,
                                                     input logic [QIDX_W-1:0] idx);
        return SLOT_AW'(SLOT_AW'(q) * SLOT_AW'(QUEUE_DEPTH)) + SLOT_AW'(idx);
    endfunction

endpackage

`default_nettype wire

// ===== design/pjd_if.sv =====
`default_nettype none

interface pjd_job_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  priority_req;
    logic [15:0] job_handle;
    logic        uses_counter;
    logic [3:0]  counter_id;
    logic [15:0] counter_value;

    modport source (output valid, kind, priority_req, job_handle, uses_counter,
                    counter_id, counter_value, input ready);
    modport sink   (input valid, kind, priority_req, job_handle, uses_counter,
                    counter_id, counter_value, output ready);
endinterface

interface pjd_res_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [1:0]  status;
    logic [15:0] job_out;
    logic        job_uses_counter;
    logic [3:0]  job_counter_id;
    logic [15:0] counter_count;
    logic        counter_complete;
    logic        counter_just_finished;
    logic [5:0]  pending_jobs;

    modport source (output valid, accepted, status, job_out, job_uses_counter,
                    job_counter_id, counter_count, counter_complete,
                    counter_just_finished, pending_jobs, input ready);
    modport sink   (input valid, accepted, status, job_out, job_uses_counter,
                    job_counter_id, counter_count, counter_complete,
                    counter_just_finished, pending_jobs, output ready);
endinterface

`default_nettype wire

// ===== design/pjd_slot_ram.sv =====
`default_nettype none

// Job slot store: all FIFOs share one RAM, queue q owns rows q*depth onwards.
module pjd_slot_ram (
    input  wire              i_clk,
    input  pjd_pkg::t_slot_wr i_wr,
    input  pjd_pkg::t_slot_rd i_rd,
    output pjd_pkg::t_slot    o_rdata
);

    pjd_pkg::t_slot r_mem [pjd_pkg::SLOT_N];
    pjd_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/pjd_ctr_store.sv =====
`default_nettype none

// Completion counters. Per-entry valid bits stand in for the zero reset.
module pjd_ctr_store (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  pjd_pkg::t_ctr_wr i_wr,
    input  pjd_pkg::t_ctr_rd i_rd,
    output logic [15:0]      o_rdata
);

    logic [15:0]                    r_mem [pjd_pkg::NUM_COUNTERS];
    logic [pjd_pkg::NUM_COUNTERS-1:0] r_valid;
    logic [15:0]                    r_rdata;
    logic                           r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_valid <= r_valid[i_rd.addr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : 16'd0;

endmodule

`default_nettype wire

// ===== design/priority_job_dispatcher.sv =====
// Result path: the accepting edge moves the sequencer to EXEC, which loads the result
// register; the result stays there until it is taken.
// Flow: a new transaction is taken only after the two-step sequencer (read the slot and
// counter memories, then modify and write back) is done with the last one; a result held
// in the output register blocks the next transaction until it is taken.
// Reset: synchronous, active low; clears FIFO pointers, fills, pending total and counter
// valid bits at once, so no clearing pass is needed. Job slots are not reset.
`default_nettype none

module priority_job_dispatcher (
    input  wire       i_clk,
    input  wire       i_rst_n,
    pjd_job_if.sink   i_job,
    pjd_res_if.source o_res
);

    localparam int QD = pjd_pkg::QUEUE_DEPTH;
    localparam int NP = pjd_pkg::NUM_PRIORITIES;

    // Two-step sequencer: IDLE takes a transaction and launches the memory reads,
    // EXEC sees the read data, writes back and loads the result register.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    // per-FIFO pointers, small enough for flops
    logic [pjd_pkg::QIDX_W-1:0] r_head [NP];
    logic [pjd_pkg::FILL_W-1:0] r_fill [NP];
    logic [pjd_pkg::PEND_W-1:0] r_pending;

    // transaction held across the read cycle
    pjd_pkg::t_kind              r_kind;
    logic [pjd_pkg::PRIO_W-1:0]  r_qsel;
    logic                        r_hit;
    logic [pjd_pkg::QIDX_W-1:0]  r_head_q;
    logic [pjd_pkg::FILL_W-1:0]  r_fill_q;
    logic [15:0]                 r_handle;
    logic                        r_uses;
    logic [3:0]                  r_cid_raw;
    logic [pjd_pkg::CIDX_W-1:0]  r_cidx;
    logic [15:0]                 r_cval;

    // result register
    logic        r_out_valid;
    logic        r_accepted;
    logic [1:0]  r_status;
    logic [15:0] r_job_out;
    logic        r_job_uses;
    logic [3:0]  r_job_cid;
    logic [15:0] r_ctr_count;
    logic        r_ctr_complete;
    logic        r_ctr_just;
    logic [5:0]  r_pend_out;

    logic in_fire, out_fire;

    // accept-side selection
    logic [pjd_pkg::PRIO_W-1:0] sel_take;
    logic                       any_pending;
    logic [pjd_pkg::PRIO_W-1:0] prio_sat;
    logic [pjd_pkg::PRIO_W-1:0] n_qsel;

    // exec-side results
    pjd_pkg::t_slot             slot_rd;
    logic [15:0]                ctr_rd;
    pjd_pkg::t_slot_wr          slot_wr;
    pjd_pkg::t_slot_rd          slot_rq;
    pjd_pkg::t_ctr_wr           ctr_wr;
    pjd_pkg::t_ctr_rd           ctr_rq;
    logic                       q_full;
    logic [pjd_pkg::QIDX_W+1:0] tail_sum;
    logic [pjd_pkg::QIDX_W-1:0] tail_idx;
    logic [pjd_pkg::QIDX_W-1:0] head_next;
    logic                       q_upd;
    logic [pjd_pkg::FILL_W-1:0] n_fill_q;
    logic [pjd_pkg::QIDX_W-1:0] n_head_q;
    logic [pjd_pkg::PEND_W-1:0] n_pending;
    logic                       n_accepted;
    logic [1:0]                 n_status;
    logic [15:0]                n_job_out;
    logic                       n_job_uses;
    logic [3:0]                 n_job_cid;
    logic [15:0]                n_ctr;
    logic                       n_ctr_just;

    // Input is taken only when idle and the result register is free, or frees
    // this cycle, so EXEC can always load it.
    assign i_job.ready = r_state[0] && (!r_out_valid || o_res.ready);
    assign in_fire     = i_job.valid && i_job.ready;
    assign out_fire    = r_out_valid && o_res.ready;

    // Highest non-empty FIFO wins a take; scan from lowest so priority 0 ends up last.
    always_comb begin
        sel_take    = '0;
        any_pending = 1'b0;
        for (int p = NP - 1; p >= 0; p--) begin
            if (r_fill[p] != '0) begin
                sel_take    = pjd_pkg::PRIO_W'(p);
                any_pending = 1'b1;
            end
        end
    end

    // out-of-range priority falls to the lowest queue
    assign prio_sat = (32'(i_job.priority_req) >= 32'(NP))
                    ? pjd_pkg::PRIO_W'(NP - 1)
                    : pjd_pkg::PRIO_W'(i_job.priority_req);

    assign n_qsel = (pjd_pkg::t_kind'(i_job.kind) == pjd_pkg::KIND_TAKE) ? sel_take
                                                                         : prio_sat;

    // read the head slot of the chosen FIFO and the addressed counter on accept
    assign slot_rq.en   = in_fire;
    assign slot_rq.addr = pjd_pkg::slot_addr(n_qsel, r_head[n_qsel]);
    assign ctr_rq.en    = in_fire;
    assign ctr_rq.addr  = pjd_pkg::CTR_MAP[i_job.counter_id];

    pjd_slot_ram u_slot_ram (
        .i_clk   (i_clk),
        .i_wr    (slot_wr),
        .i_rd    (slot_rq),
        .o_rdata (slot_rd)
    );

    pjd_ctr_store u_ctr_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (ctr_wr),
        .i_rd    (ctr_rq),
        .o_rdata (ctr_rd)
    );

    // tail = (head + fill) mod depth; the sum stays under twice the depth
    assign q_full   = (r_fill_q == pjd_pkg::FILL_W'(QD));
    assign tail_sum = (pjd_pkg::QIDX_W + 2)'(r_head_q) + (pjd_pkg::QIDX_W + 2)'(r_fill_q);
    assign tail_idx = (tail_sum >= (pjd_pkg::QIDX_W + 2)'(QD))
                    ? pjd_pkg::QIDX_W'(tail_sum - (pjd_pkg::QIDX_W + 2)'(QD))
                    : pjd_pkg::QIDX_W'(tail_sum);
    assign head_next = (32'(r_head_q) + 32'd1 >= 32'(QD)) ? '0
                                                         : r_head_q + pjd_pkg::QIDX_W'(1);

    always_comb begin
        slot_wr.en        = 1'b0;
        slot_wr.addr      = pjd_pkg::slot_addr(r_qsel, tail_idx);
        slot_wr.data.handle  = r_handle;
        slot_wr.data.has_ctr = r_uses;
        slot_wr.data.ctr_id  = r_uses ? r_cid_raw : 4'd0;

        ctr_wr.en   = 1'b0;
        ctr_wr.addr = r_cidx;
        ctr_wr.data = r_cval;

        q_upd      = 1'b0;
        n_fill_q   = r_fill_q;
        n_head_q   = r_head_q;
        n_pending  = r_pending;
        n_accepted = 1'b0;
        n_status   = pjd_pkg::STATUS_OK;
        n_job_out  = 16'd0;
        n_job_uses = 1'b0;
        n_job_cid  = 4'd0;
        n_ctr      = ctr_rd;
        n_ctr_just = 1'b0;

        unique case (r_kind)
            pjd_pkg::KIND_SUBMIT: begin
                if (q_full) begin
                    n_status = pjd_pkg::STATUS_FULL;
                end else begin
                    slot_wr.en = 1'b1;
                    q_upd      = 1'b1;
                    n_fill_q   = r_fill_q + pjd_pkg::FILL_W'(1);
                    n_pending  = r_pending + pjd_pkg::PEND_W'(1);
                    n_accepted = 1'b1;
                end
            end
            pjd_pkg::KIND_TAKE: begin
                if (r_hit) begin
                    q_upd      = 1'b1;
                    n_fill_q   = r_fill_q - pjd_pkg::FILL_W'(1);
                    n_head_q   = head_next;
                    n_pending  = (r_pending != '0) ? r_pending - pjd_pkg::PEND_W'(1)
                                                   : r_pending;
                    n_accepted = 1'b1;
                    n_job_out  = slot_rd.handle;
                    n_job_uses = slot_rd.has_ctr;
                    n_job_cid  = slot_rd.has_ctr ? slot_rd.ctr_id : 4'd0;
                end else begin
                    n_status = pjd_pkg::STATUS_NONE;
                end
            end
            pjd_pkg::KIND_FINISH: begin
                // saturating decrement; only a 1 -> 0 step counts as finished
                if (r_uses && ctr_rd != 16'd0) begin
                    ctr_wr.en   = 1'b1;
                    ctr_wr.data = ctr_rd - 16'd1;
                    n_ctr       = ctr_rd - 16'd1;
                    n_ctr_just  = (ctr_rd == 16'd1);
                end
            end
            pjd_pkg::KIND_SET: begin
                ctr_wr.en = 1'b1;
                n_ctr     = r_cval;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = in_fire ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pending   <= '0;
            for (int p = 0; p < NP; p++) begin
                r_head[p] <= '0;
                r_fill[p] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state[1]) begin
                r_out_valid <= 1'b1;
                r_pending   <= n_pending;
                if (q_upd) begin
                    r_head[r_qsel] <= n_head_q;
                    r_fill[r_qsel] <= n_fill_q;
                end
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction capture; pointers of the chosen FIFO cannot change until EXEC
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind    <= pjd_pkg::t_kind'(i_job.kind);
            r_qsel    <= n_qsel;
            r_hit     <= any_pending;
            r_head_q  <= r_head[n_qsel];
            r_fill_q  <= r_fill[n_qsel];
            r_handle  <= i_job.job_handle;
            r_uses    <= i_job.uses_counter;
            r_cid_raw <= i_job.counter_id;
            r_cidx    <= ctr_rq.addr;
            r_cval    <= i_job.counter_value;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state[1]) begin
            r_accepted     <= n_accepted;
            r_status       <= n_status;
            r_job_out      <= n_job_out;
            r_job_uses     <= n_job_uses;
            r_job_cid      <= n_job_cid;
            r_ctr_count    <= n_ctr;
            r_ctr_complete <= (n_ctr == 16'd0);
            r_ctr_just     <= n_ctr_just;
            r_pend_out     <= (32'(n_pending) > pjd_pkg::PEND_MAX) ? 6'(pjd_pkg::PEND_MAX)
                                                                  : 6'(n_pending);
        end
    end

    assign o_res.valid                 = r_out_valid;
    assign o_res.accepted              = r_accepted;
    assign o_res.status                = r_status;
    assign o_res.job_out               = r_job_out;
    assign o_res.job_uses_counter      = r_job_uses;
    assign o_res.job_counter_id        = r_job_cid;
    assign o_res.counter_count         = r_ctr_count;
    assign o_res.counter_complete      = r_ctr_complete;
    assign o_res.counter_just_finished = r_ctr_just;
    assign o_res.pending_jobs          = r_pend_out;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no transaction on either side before the run is declared hung.
    // Even the longest chain of random stalls stays far below this.
    localparam int HANG_LIMIT = 2000;
    // Cycles to let the pipeline settle after the last result.
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 330;
    // At most two results are ever owed at once; a small ring is plenty.
    localparam int DUE_DEPTH = 8;
    localparam int DIR_MAX = 32;

    // One request as it goes onto the job channel
    typedef struct packed {
        pjd_pkg::t_kind kind;
        logic [1:0]     prio;
        logic [15:0]    handle;
        logic           uses;
        logic [3:0]     cid;
        logic [15:0]    cval;
    } t_job_req;

    // One dispatch result as it comes off the result channel
    typedef struct packed {
        logic             accepted;
        pjd_pkg::t_status status;
        logic [15:0]      job_out;
        logic             job_uses_counter;
        logic [3:0]       job_counter_id;
        logic [15:0]      counter_count;
        logic             counter_complete;
        logic             counter_just_finished;
        logic [5:0]       pending_jobs;
    } t_dispatch_result;

    // Directed table row: the request is sent reps times, handle stepping by
    // one each time. Where typed is set, want is the result read off by hand.
    typedef struct packed {
        t_job_req         req;
        int               reps;
        bit               typed;
        t_dispatch_result want;
    } t_dir_row;

    logic clk;
    logic rst_n;
    bit   quiet;        // no idling on either side while set
    int   fail_count;
    int   hang_count;

    pjd_job_if job_if ();
    pjd_res_if res_if ();

    priority_job_dispatcher i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_job   (job_if.sink),
        .o_res   (res_if.source)
    );

    // ------------------------------------------------------------------
    // Local copy of the dispatcher state, advanced once per accepted
    // transaction on the job channel.
    // ------------------------------------------------------------------
    pjd_pkg::t_slot fifo_slot [pjd_pkg::NUM_PRIORITIES][pjd_pkg::QUEUE_DEPTH];
    int unsigned    fifo_head [pjd_pkg::NUM_PRIORITIES];
    int unsigned    fifo_fill [pjd_pkg::NUM_PRIORITIES];
    logic [15:0]    ctr_val   [pjd_pkg::NUM_COUNTERS];
    int unsigned    jobs_queued;

    // results owed by the block, oldest at due_rd
    t_dispatch_result due_buf [DUE_DEPTH];
    int unsigned      due_wr = 0;
    int unsigned      due_rd = 0;

    t_dir_row dir_rows [DIR_MAX];
    int       dir_n = 0;

    initial clk = 1'b0;
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic t_job_req mk_req(input pjd_pkg::t_kind kind, input logic [1:0] prio,
                                        input logic [15:0] handle, input logic uses,
                                        input logic [3:0] cid, input logic [15:0] cval);
        t_job_req r;
        r = '{kind, prio, handle, uses, cid, cval};
        return r;
    endfunction

    function automatic t_dispatch_result mk_res(input logic acc, input pjd_pkg::t_status st,
                                                input logic [15:0] count, input logic done,
                                                input logic just, input logic [5:0] pend);
        t_dispatch_result w;
        w = '{acc, st, 16'd0, 1'b0, 4'd0, count, done, just, pend};
        return w;
    endfunction

    function automatic void add_row(input t_dir_row row);
        dir_rows[dir_n] = row;
        dir_n++;
    endfunction

    // Works out the result of one request and moves the local state on.
    function automatic t_dispatch_result predict_dispatch(input t_job_req r);
        t_dispatch_result res;
        int unsigned      q;
        int unsigned      c;
        int unsigned      idx;
        res        = '0;
        res.status = pjd_pkg::STATUS_OK;
        // out-of-range priority falls to the lowest queue
        q = (r.prio >= pjd_pkg::NUM_PRIORITIES) ? pjd_pkg::NUM_PRIORITIES - 1 : r.prio;
        c = r.cid % pjd_pkg::NUM_COUNTERS;
        case (r.kind)
            pjd_pkg::KIND_SUBMIT: begin
                if (fifo_fill[q] >= pjd_pkg::QUEUE_DEPTH) begin
                    res.status = pjd_pkg::STATUS_FULL;
                end else begin
                    idx = (fifo_head[q] + fifo_fill[q]) % pjd_pkg::QUEUE_DEPTH;
                    fifo_slot[q][idx].handle  = r.handle;
                    fifo_slot[q][idx].has_ctr = r.uses;
                    fifo_slot[q][idx].ctr_id  = r.uses ? r.cid : 4'd0;
                    fifo_fill[q]++;
                    jobs_queued++;
                    res.accepted = 1'b1;
                end
            end
            pjd_pkg::KIND_TAKE: begin
                res.status = pjd_pkg::STATUS_NONE;
                for (int p = 0; p < pjd_pkg::NUM_PRIORITIES; p++) begin
                    if (fifo_fill[p] != 0) begin
                        idx = fifo_head[p] % pjd_pkg::QUEUE_DEPTH;
                        res.job_out          = fifo_slot[p][idx].handle;
                        res.job_uses_counter = fifo_slot[p][idx].has_ctr;
                        res.job_counter_id   = fifo_slot[p][idx].has_ctr ?
                                               fifo_slot[p][idx].ctr_id : 4'd0;
                        fifo_head[p] = (idx + 1) % pjd_pkg::QUEUE_DEPTH;
                        fifo_fill[p]--;
                        if (jobs_queued != 0) jobs_queued--;
                        res.accepted = 1'b1;
                        res.status   = pjd_pkg::STATUS_OK;
                        break;
                    end
                end
            end
            pjd_pkg::KIND_FINISH: begin
                // saturating decrement, only for jobs that carry a counter
                if (r.uses && ctr_val[c] != 16'd0) begin
                    ctr_val[c] = ctr_val[c] - 16'd1;
                    res.counter_just_finished = (ctr_val[c] == 16'd0);
                end
            end
            default: begin
                ctr_val[c] = r.cval;
            end
        endcase
        res.counter_count    = ctr_val[c];
        res.counter_complete = (ctr_val[c] == 16'd0);
        res.pending_jobs     = 6'((jobs_queued > pjd_pkg::PEND_MAX) ? pjd_pkg::PEND_MAX
                                                                    : jobs_queued);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $realtime, field, got, want);
        fail_count++;
    endtask

    // Puts one request on the job channel at a falling edge and holds it until
    // the block takes it; the expectation is worked out at that rising edge.
    task automatic drive_request(input t_job_req r, input bit typed,
                                 input t_dispatch_result want);
        t_dispatch_result predicted;
        while (!quiet && $urandom_range(0, 99) < 10) begin
            job_if.valid <= 1'b0;
            @(negedge clk);
        end
        job_if.valid         <= 1'b1;
        job_if.kind          <= r.kind;
        job_if.priority_req  <= r.prio;
        job_if.job_handle    <= r.handle;
        job_if.uses_counter  <= r.uses;
        job_if.counter_id    <= r.cid;
        job_if.counter_value <= r.cval;
        @(posedge clk);
        while (!job_if.ready) @(posedge clk);
        // state always advances, even where the row carries a hand-typed result
        predicted = predict_dispatch(r);
        due_buf[due_wr % DUE_DEPTH] = typed ? want : predicted;
        due_wr++;
        @(negedge clk);
    endtask

    // Result side: ready drops at random about ten percent of the time unless quiet.
    always @(negedge clk) begin
        res_if.ready <= rst_n && (quiet || $urandom_range(0, 99) >= 10);
    end

    // Checker: each result transaction against the oldest expectation.
    always @(posedge clk) begin
        t_dispatch_result got;
        t_dispatch_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.accepted, pjd_pkg::t_status'(res_if.status), res_if.job_out,
                    res_if.job_uses_counter, res_if.job_counter_id,
                    res_if.counter_count, res_if.counter_complete,
                    res_if.counter_just_finished, res_if.pending_jobs};
            if (due_wr == due_rd) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = due_buf[due_rd % DUE_DEPTH];
                due_rd++;
                if (got.accepted !== want.accepted)
                    report_mismatch("accepted", got.accepted, want.accepted);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.job_out !== want.job_out)
                    report_mismatch("job_out", got.job_out, want.job_out);
                if (got.job_uses_counter !== want.job_uses_counter)
                    report_mismatch("job_uses_counter", got.job_uses_counter,
                                    want.job_uses_counter);
                if (got.job_counter_id !== want.job_counter_id)
                    report_mismatch("job_counter_id", got.job_counter_id,
                                    want.job_counter_id);
                if (got.counter_count !== want.counter_count)
                    report_mismatch("counter_count", got.counter_count,
                                    want.counter_count);
                if (got.counter_complete !== want.counter_complete)
                    report_mismatch("counter_complete", got.counter_complete,
                                    want.counter_complete);
                if (got.counter_just_finished !== want.counter_just_finished)
                    report_mismatch("counter_just_finished", got.counter_just_finished,
                                    want.counter_just_finished);
                if (got.pending_jobs !== want.pending_jobs)
                    report_mismatch("pending_jobs", got.pending_jobs, want.pending_jobs);
            end
        end
    end

    // Watchdog: counts cycles with no transaction on either channel.
    always @(posedge clk) begin
        if ((job_if.valid && job_if.ready) || (res_if.valid && res_if.ready)) begin
            hang_count <= 0;
        end else if (hang_count >= HANG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            hang_count <= hang_count + 1;
        end
    end

    initial begin
        t_job_req req;
        int       mode;
        int       hot;
        int       roll;
        int       sub_pct;
        int       take_pct;

        fail_count = 0;
        hang_count = 0;
        quiet      = 1'b0;
        rst_n      = 1'b0;
        job_if.valid         = 1'b0;
        job_if.kind          = pjd_pkg::KIND_SUBMIT;
        job_if.priority_req  = 2'd0;
        job_if.job_handle    = 16'd0;
        job_if.uses_counter  = 1'b0;
        job_if.counter_id    = 4'd0;
        job_if.counter_value = 16'd0;
        res_if.ready         = 1'b0;

        for (int p = 0; p < pjd_pkg::NUM_PRIORITIES; p++) begin
            fifo_head[p] = 0;
            fifo_fill[p] = 0;
        end
        foreach (ctr_val[i]) ctr_val[i] = 16'd0;
        jobs_queued = 0;

        // --- directed table ---------------------------------------------
        // take on an empty dispatcher straight out of reset
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_TAKE, 2'd0, 16'd0, 1'b0, 4'd0, 16'd0), 1, 1'b1,
            mk_res(1'b0, pjd_pkg::STATUS_NONE, 16'd0, 1'b1, 1'b0, 6'd0)});
        // finish on a counter already at zero stays at zero
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_FINISH, 2'd0, 16'd0, 1'b1, 4'd5, 16'd0), 1, 1'b1,
            mk_res(1'b0, pjd_pkg::STATUS_OK, 16'd0, 1'b1, 1'b0, 6'd0)});
        // top counter loaded with the largest count
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_SET, 2'd0, 16'd0, 1'b0, 4'd15, 16'hFFFF), 1, 1'b1,
            mk_res(1'b0, pjd_pkg::STATUS_OK, 16'hFFFF, 1'b0, 1'b0, 6'd0)});
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_SET, 2'd0, 16'd0, 1'b0, 4'd4, 16'd1), 1, 1'b1,
            mk_res(1'b0, pjd_pkg::STATUS_OK, 16'd1, 1'b0, 1'b0, 6'd0)});
        // one to zero: the just-finished flag
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_FINISH, 2'd0, 16'd0, 1'b1, 4'd4, 16'd0), 1, 1'b1,
            mk_res(1'b0, pjd_pkg::STATUS_OK, 16'd0, 1'b1, 1'b1, 6'd0)});
        // finish without counter leaves it alone but still reports it
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_FINISH, 2'd3, 16'd0, 1'b0, 4'd15, 16'd0), 1, 1'b1,
            mk_res(1'b0, pjd_pkg::STATUS_OK, 16'hFFFF, 1'b0, 1'b0, 6'd0)});
        // priority 3 is clamped onto the low queue
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_SUBMIT, 2'd3, 16'hFFFF, 1'b1, 4'd15, 16'hFFFF), 1, 1'b1,
            mk_res(1'b1, pjd_pkg::STATUS_OK, 16'hFFFF, 1'b0, 1'b0, 6'd1)});
        // submit without counter: stored id must come back as zero
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_SUBMIT, 2'd0, 16'h0000, 1'b0, 4'd9, 16'd0), 1, 1'b0, '0});
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_SUBMIT, 2'd1, 16'h1234, 1'b1, 4'd3, 16'd0), 1, 1'b0, '0});
        // three takes in priority order, then one on empty
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_TAKE, 2'd2, 16'd0, 1'b0, 4'd15, 16'd0), 4, 1'b0, '0});
        // count down through zero and one step past it
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_SET, 2'd0, 16'd0, 1'b0, 4'd8, 16'd3), 1, 1'b0, '0});
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_FINISH, 2'd0, 16'd0, 1'b1, 4'd8, 16'd0), 4, 1'b0, '0});
        // fill each queue to the brim and one more: last submit is dropped
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_SUBMIT, 2'd2, 16'hA000, 1'b1, 4'd8, 16'd0), 17, 1'b0, '0});
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_SUBMIT, 2'd1, 16'h5000, 1'b0, 4'd2, 16'd0), 17, 1'b0, '0});
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_SUBMIT, 2'd0, 16'h0100, 1'b1, 4'd15, 16'd0), 17, 1'b0, '0});
        // drain all 48 in strict priority order, the last take finds nothing
        add_row(t_dir_row'{
            mk_req(pjd_pkg::KIND_TAKE, 2'd0, 16'd0, 1'b0, 4'd0, 16'd0), 49, 1'b0, '0});

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < dir_n; i++) begin
            for (int k = 0; k < dir_rows[i].reps; k++) begin
                req        = dir_rows[i].req;
                req.handle = req.handle + 16'(k);
                drive_request(req, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // --- random part ------------------------------------------------
        // Phases of 30 transactions: balanced, filling or draining, so the
        // queues swing between empty and full. About half the counter loads use
        // small counts so that finishes keep reaching zero.
        mode = 0;
        hot  = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 30 == 0) begin
                mode = $urandom_range(0, 2);
                hot  = $urandom_range(0, 3);
            end
            quiet = (n >= 150 && n < 300);
            case (mode)
                1:       begin sub_pct = 70; take_pct = 10; end
                2:       begin sub_pct = 15; take_pct = 65; end
                default: begin sub_pct = 35; take_pct = 30; end
            endcase
            roll = $urandom_range(0, 99);
            req.prio   = ($urandom_range(0, 99) < 70) ? 2'(hot) : 2'($urandom_range(0, 3));
            req.handle = 16'($urandom);
            req.uses   = 1'($urandom_range(0, 1));
            req.cid    = 4'($urandom_range(0, 15));
            req.cval   = 16'($urandom);
            if (roll < sub_pct) begin
                req.kind = pjd_pkg::KIND_SUBMIT;
            end else if (roll < sub_pct + take_pct) begin
                req.kind = pjd_pkg::KIND_TAKE;
            end else if (roll < sub_pct + take_pct + (100 - sub_pct - take_pct) / 2) begin
                req.kind = pjd_pkg::KIND_FINISH;
                req.uses = ($urandom_range(0, 99) < 80);
            end else begin
                req.kind = pjd_pkg::KIND_SET;
                if ($urandom_range(0, 1)) req.cval = 16'($urandom_range(0, 3));
            end
            drive_request(req, 1'b0, '0);
        end

        job_if.valid <= 1'b0;
        quiet = 1'b1;
        while (due_wr != due_rd) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
